>>> hdl/icsc_pkg.sv
// Package: shared types, constants and helper functions for the segment classifier.
`timescale 1ns / 1ps
`default_nettype none
package icsc_pkg;

  localparam int PIX_W   = 32;
  localparam int VAL_W   = 8;
  localparam int LEN_W   = 16;
  localparam int KIND_W  = 3;
  localparam int NLANE   = 5;
  localparam int MAP_W   = 256;
  localparam int CNT_W   = 9;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int LWIDTH_W   = 13;
  localparam int MINRUN_W   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW8_LEN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW32_LEN  = 2'd3;

  localparam logic [LWIDTH_W-1:0] RST_LINE_WIDTH = 13'd640;
  localparam logic [MINRUN_W-1:0] RST_MIN_RUN    = 8'd5;
  localparam logic [LEN_W-1:0]    RST_RAW8_LEN   = 16'd50;
  localparam logic [LEN_W-1:0]    RST_RAW32_LEN  = 16'd100;

  localparam logic [CNT_W-1:0] RAW8_MAX_DISTINCT  = 9'd8;
  localparam logic [CNT_W-1:0] RAW32_MAX_DISTINCT = 9'd32;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE  = 3'd0,
    KIND_HRUN  = 3'd1,
    KIND_VRUN  = 3'd2,
    KIND_RAW8  = 3'd3,
    KIND_RAW32 = 3'd4
  } kind_t;

  typedef logic [NLANE-1:0][VAL_W-1:0] lane_vals_t;

  typedef struct packed {
    logic [MINRUN_W-1:0] min_run;
    logic [LEN_W-1:0]    raw8_len;
    logic [LEN_W-1:0]    raw32_len;
  } lane_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [PIX_W-1:0] above;
    logic             frame_clr;
  } s1_item_t;

  function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
    return (v == {LEN_W{1'b1}}) ? v : v + LEN_W'(1);
  endfunction

  // floor(sum/3) as sum*683 >> 11, exact for sums up to 765
  function automatic logic [VAL_W-1:0] gray_of(input logic [PIX_W-1:0] p);
    logic [9:0]  s;
    logic [19:0] m;
    s = 10'(p[23:16]) + 10'(p[15:8]) + 10'(p[7:0]);
    m = 20'(s) * 20'd683;
    return m[18:11];
  endfunction

  function automatic lane_vals_t split_lanes(input logic [PIX_W-1:0] p);
    lane_vals_t v;
    v[0] = p[23:16];
    v[1] = p[15:8];
    v[2] = p[7:0];
    v[3] = p[31:24];
    v[4] = gray_of(p);
    return v;
  endfunction

endpackage
`default_nettype wire

>>> hdl/icsc_if.sv
// Interfaces: pixel input, segment result and configuration write channels.
`timescale 1ns / 1ps
`default_nettype none
interface icsc_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel;
  logic        frame_start;
  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface icsc_seg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  red_kind;
  logic [15:0] red_length;
  logic [2:0]  green_kind;
  logic [15:0] green_length;
  logic [2:0]  blue_kind;
  logic [15:0] blue_length;
  logic [2:0]  alpha_kind;
  logic [15:0] alpha_length;
  logic [2:0]  luma_kind;
  logic [15:0] luma_length;
  modport source (
    output valid, input ready,
    output red_kind, output red_length, output green_kind, output green_length,
    output blue_kind, output blue_length, output alpha_kind, output alpha_length,
    output luma_kind, output luma_length
  );
  modport sink (
    input valid, output ready,
    input red_kind, input red_length, input green_kind, input green_length,
    input blue_kind, input blue_length, input alpha_kind, input alpha_length,
    input luma_kind, input luma_length
  );
endinterface

interface icsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/icsc_front.sv
// Input stage: column tracking, line buffer and registered vertical neighbour.
`timescale 1ns / 1ps
`default_nettype none
module icsc_front
  import icsc_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  icsc_pix_if.sink                 in_ch,
  input  wire logic [LWIDTH_W-1:0] line_width,
  input  wire logic                advance,
  output logic                     s1_valid,
  output s1_item_t                 s1_item
);

  localparam int AW = $clog2(MAX_LINE_WIDTH);
  localparam int WW = $clog2(MAX_LINE_WIDTH + 1);
  localparam int LW = (WW > LWIDTH_W) ? WW : LWIDTH_W;

  logic [PIX_W-1:0] line_mem [MAX_LINE_WIDTH];

  logic [AW-1:0]    col_r, col_nxt, col_c;
  logic             first_r, first_nxt, first_c;
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pixel_r, rd_data_r;
  logic             s1_first_r, s1_frame_r;
  logic [LW-1:0]    w_raw, w_eff, col_inc;
  logic             wrap, accept;

  assign in_ch.ready = !s1_valid_r || advance;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    col_c   = in_ch.frame_start ? '0 : col_r;
    first_c = in_ch.frame_start || first_r;
    w_raw   = LW'(line_width);
    if (w_raw == '0) begin
      w_eff = LW'(1);
    end else if (w_raw > LW'(MAX_LINE_WIDTH)) begin
      w_eff = LW'(MAX_LINE_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    col_inc   = LW'(col_c) + LW'(1);
    wrap      = col_inc >= w_eff;
    col_nxt   = wrap ? '0 : col_inc[AW-1:0];
    first_nxt = first_c && !wrap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      first_r    <= 1'b1;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r   <= col_nxt;
        first_r <= first_nxt;
      end
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
    end
  end

  // read-before-write: the read returns the pixel one line up
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r       <= line_mem[col_c];
      line_mem[col_c] <= in_ch.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel_r <= in_ch.pixel;
      s1_first_r <= first_c;
      s1_frame_r <= in_ch.frame_start;
    end
  end

  assign s1_valid          = s1_valid_r;
  assign s1_item.pixel     = s1_pixel_r;
  assign s1_item.above     = s1_first_r ? '0 : rd_data_r;
  assign s1_item.frame_clr = s1_frame_r;

endmodule
`default_nettype wire

>>> hdl/icsc_lane.sv
// One channel lane: run tracking, seen-value map and segment decision.
`timescale 1ns / 1ps
`default_nettype none
module icsc_lane
  import icsc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             frame_clr,
  input  wire logic [VAL_W-1:0] cur,
  input  wire logic [VAL_W-1:0] above,
  input  wire lane_cfg_t        cfg,
  output kind_t                 kind,
  output logic [LEN_W-1:0]      length
);

  logic [VAL_W-1:0] prev_r, prev_nxt, prev_c;
  logic [LEN_W-1:0] hrun_r, hrun_nxt, hrun_c, hrun_upd, hrep, hcand;
  logic [LEN_W-1:0] vrun_r, vrun_nxt, vrun_c, vrun_upd, vrep, vcand;
  logic [MAP_W-1:0] seen_r, seen_nxt, seen_c, seen_upd;
  logic [CNT_W-1:0] dcount_r, dcount_nxt, dcount_c, dcount_upd;
  logic [LEN_W-1:0] seg_r, seg_nxt, seg_c, seg_upd;
  logic             report;

  always_comb begin
    prev_c   = frame_clr ? '0 : prev_r;
    hrun_c   = frame_clr ? '0 : hrun_r;
    vrun_c   = frame_clr ? '0 : vrun_r;
    seen_c   = frame_clr ? '0 : seen_r;
    dcount_c = frame_clr ? '0 : dcount_r;
    seg_c    = frame_clr ? '0 : seg_r;

    seg_upd    = sat_inc(seg_c);
    dcount_upd = dcount_c + CNT_W'(!seen_c[cur]);
    seen_upd   = seen_c | (MAP_W'(1) << cur);

    if (cur == above) begin
      vrun_upd = sat_inc(vrun_c);
      vrep     = '0;
    end else begin
      vrun_upd = '0;
      vrep     = vrun_c;
    end

    if (cur == prev_c) begin
      hrun_upd = sat_inc(hrun_c);
      hrep     = '0;
    end else begin
      hrun_upd = '0;
      hrep     = hrun_c;
    end

    hcand = (hrep < LEN_W'(cfg.min_run)) ? '0 : hrep;
    vcand = (vrep < LEN_W'(cfg.min_run)) ? '0 : vrep;

    kind   = KIND_NONE;
    length = '0;
    if (hcand > vcand) begin
      kind   = KIND_HRUN;
      length = hcand;
    end else if (vcand != '0) begin
      kind   = KIND_VRUN;
      length = vcand;
    end else if (dcount_upd <= RAW8_MAX_DISTINCT && seg_upd > cfg.raw8_len) begin
      kind   = KIND_RAW8;
      length = seg_upd;
    end else if (dcount_upd <= RAW32_MAX_DISTINCT && seg_upd > cfg.raw32_len) begin
      kind   = KIND_RAW32;
      length = seg_upd;
    end
    report = kind != KIND_NONE;

    prev_nxt   = cur;
    hrun_nxt   = report ? '0 : hrun_upd;
    vrun_nxt   = report ? '0 : vrun_upd;
    seen_nxt   = report ? '0 : seen_upd;
    dcount_nxt = report ? '0 : dcount_upd;
    seg_nxt    = report ? '0 : seg_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      hrun_r   <= '0;
      vrun_r   <= '0;
      seen_r   <= '0;
      dcount_r <= '0;
      seg_r    <= '0;
    end else if (en) begin
      prev_r   <= prev_nxt;
      hrun_r   <= hrun_nxt;
      vrun_r   <= vrun_nxt;
      seen_r   <= seen_nxt;
      dcount_r <= dcount_nxt;
      seg_r    <= seg_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/image_channel_segment_classifier.sv
// Top level: configuration registers, channel lanes and result register.
//
// Usage:
//   in_ch   pixel stream; one packed ARGB pixel per transfer, frame_start on
//           the first pixel of each image clears the column, row and lane state.
//   out_ch  one result per pixel: kind and length for red, green, blue, alpha
//           and gray lanes, in input order.
//   cfg_ch  register writes (line width, minimum run, raw8/raw32 lengths);
//           always ready, to be written only while the block is idle.
// A transferred pixel and its line buffer read are captured in the input
// register, then the lane update is written into the result register, which
// drives out_ch. Throughput is one pixel per cycle while out_ch is not
// stalled, set by the update loop of each lane's state.
// Reset (rst_n low, synchronous) empties both stages, restores the register
// defaults and starts a new frame; line buffer contents are not cleared.
// When the receiver stalls the result is held and one more pixel is taken into
// the first stage if it is empty; after that in_ch.ready drops until out_ch moves.
`timescale 1ns / 1ps
`default_nettype none
module image_channel_segment_classifier
  import icsc_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = 4096,
  parameter int LANES          = 5
) (
  input  wire logic clk,
  input  wire logic rst_n,
  icsc_pix_if.sink    in_ch,
  icsc_seg_if.source  out_ch,
  icsc_cfg_if.sink    cfg_ch
);

  logic [LWIDTH_W-1:0] line_width_r;
  lane_cfg_t           lane_cfg_r;

  logic                advance;
  logic                s1_valid;
  s1_item_t            s1_item;
  lane_vals_t          cur_vals, above_vals;

  kind_t               kind_c  [NLANE];
  logic [LEN_W-1:0]    len_c   [NLANE];
  kind_t               kind_r  [NLANE];
  logic [LEN_W-1:0]    len_r   [NLANE];
  logic                out_valid_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r         <= RST_LINE_WIDTH;
      lane_cfg_r.min_run   <= RST_MIN_RUN;
      lane_cfg_r.raw8_len  <= RST_RAW8_LEN;
      lane_cfg_r.raw32_len <= RST_RAW32_LEN;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_LINE_WIDTH: line_width_r         <= cfg_ch.data[LWIDTH_W-1:0];
        CFG_MIN_RUN:    lane_cfg_r.min_run   <= cfg_ch.data[MINRUN_W-1:0];
        CFG_RAW8_LEN:   lane_cfg_r.raw8_len  <= cfg_ch.data;
        CFG_RAW32_LEN:  lane_cfg_r.raw32_len <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign advance = !out_valid_r || out_ch.ready;

  icsc_front #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .line_width (line_width_r),
    .advance    (advance),
    .s1_valid   (s1_valid),
    .s1_item    (s1_item)
  );

  assign cur_vals   = split_lanes(s1_item.pixel);
  assign above_vals = split_lanes(s1_item.above);

  for (genvar k = 0; k < NLANE; k++) begin : g_lane
    if (k < LANES) begin : g_on
      icsc_lane u_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (s1_valid && advance),
        .frame_clr (s1_item.frame_clr),
        .cur       (cur_vals[k]),
        .above     (above_vals[k]),
        .cfg       (lane_cfg_r),
        .kind      (kind_c[k]),
        .length    (len_c[k])
      );
    end else begin : g_off
      assign kind_c[k] = KIND_NONE;
      assign len_c[k]  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      kind_r <= kind_c;
      len_r  <= len_c;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.red_kind     = kind_r[0];
  assign out_ch.red_length   = len_r[0];
  assign out_ch.green_kind   = kind_r[1];
  assign out_ch.green_length = len_r[1];
  assign out_ch.blue_kind    = kind_r[2];
  assign out_ch.blue_length  = len_r[2];
  assign out_ch.alpha_kind   = kind_r[3];
  assign out_ch.alpha_length = len_r[3];
  assign out_ch.luma_kind    = kind_r[4];
  assign out_ch.luma_length  = len_r[4];

endmodule
`default_nettype wire
